[sv/lsh_pkg.sv]
// Shared constants, types and helper functions of the latency statistics histogram.
package lsh_pkg;

    localparam int LATENCY_BITS = 32;
    localparam int BIN_COUNT    = 33;
    localparam int COUNT_BITS   = 48;
    localparam int SUM_BITS     = 64;
    localparam int MODE_BITS    = 2;
    localparam int IDX_BITS     = 6;
    localparam int BIN_BITS     = $clog2(BIN_COUNT);
    localparam int LEN_BITS     = $clog2(LATENCY_BITS + 1);

    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    localparam int IN_DATA_BITS  = 40;
    localparam int OUT_DATA_BITS = 560;

    localparam logic [MODE_BITS-1:0] MODE_RECORD = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_READ   = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_CLOSE  = 2'd2;

    // One classified item as it travels from the front part to the back part.
    typedef struct packed {
        logic [MODE_BITS-1:0]    mode;
        logic [LATENCY_BITS-1:0] latency;
        logic                    failed;
        logic                    idx_ok;
        logic [BIN_BITS-1:0]     idx;
        logic [BIN_BITS-1:0]     sbin;
        logic [SUM_BITS-1:0]     square;
    } item_t;

    // One result item; the first member sits in the highest bits.
    typedef struct packed {
        logic [COUNT_BITS-1:0]   bin_count;
        logic [COUNT_BITS-1:0]   period_fails;
        logic [LATENCY_BITS-1:0] period_max;
        logic [LATENCY_BITS-1:0] period_min;
        logic [SUM_BITS-1:0]     period_latency_sum;
        logic [COUNT_BITS-1:0]   period_events;
        logic [SUM_BITS-1:0]     square_sum;
        logic [COUNT_BITS-1:0]   fail_count;
        logic [LATENCY_BITS-1:0] latency_max;
        logic [LATENCY_BITS-1:0] latency_min;
        logic [SUM_BITS-1:0]     latency_sum;
        logic [COUNT_BITS-1:0]   event_count;
    } result_t;

    // Smallest r with 2^r >= lat, limited to the last bin.
    function automatic logic [BIN_BITS-1:0] ceil_log2_bin(input logic [LATENCY_BITS-1:0] lat);
        logic [LATENCY_BITS-1:0] m;
        logic [LEN_BITS-1:0]     len;
        logic [BIN_BITS-1:0]     bin;
        m   = (lat == '0) ? '0 : lat - 1'b1;
        len = '0;
        for (int i = 0; i < LATENCY_BITS; i++)
        begin
            if (m[i])
            begin
                len = LEN_BITS'(i + 1);
            end
        end
        if (32'(len) >= BIN_COUNT - 1)
        begin
            bin = BIN_BITS'(BIN_COUNT - 1);
        end
        else
        begin
            bin = BIN_BITS'(len);
        end
        return bin;
    endfunction

    function automatic logic [COUNT_BITS-1:0] count_inc(input logic [COUNT_BITS-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] a,
                                                     input logic [SUM_BITS-1:0] b);
        logic [SUM_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_BITS] ? '1 : s[SUM_BITS-1:0];
    endfunction

endpackage

[sv/lsh_ram.sv]
// Generic RAM with one write port and two registered read ports.
module lsh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr_a,
    input  logic [ADDR_BITS-1:0] rd_addr_b,
    output logic [WIDTH-1:0]     rd_data_a,
    output logic [WIDTH-1:0]     rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Reads return the contents from before a write at the same edge.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

[sv/lsh_front.sv]
// Front part: input register, bin classification and squaring of the sample.
module lsh_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [lsh_pkg::IN_DATA_BITS-1:0] s_tdata,
    input  logic [lsh_pkg::MODE_BITS-1:0]    s_tuser,
    input  logic                             q_full,
    output logic                             push,
    output lsh_pkg::item_t                   push_item
);

    logic                               f_valid_reg;
    logic [lsh_pkg::MODE_BITS-1:0]      f_mode_reg;
    logic [lsh_pkg::LATENCY_BITS-1:0]   f_lat_reg;
    logic                               f_fail_reg;
    logic [lsh_pkg::IDX_BITS-1:0]       f_idx_reg;
    logic [2*lsh_pkg::LATENCY_BITS-1:0] product;
    logic                               accept;

    assign s_tready = !f_valid_reg || !q_full;
    assign accept   = s_tvalid && s_tready;
    assign push     = f_valid_reg && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            f_valid_reg <= 1'b1;
        end
        else if (push)
        begin
            f_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f_mode_reg <= s_tuser;
            f_lat_reg  <= s_tdata[lsh_pkg::LATENCY_BITS-1:0];
            f_fail_reg <= s_tdata[32];
            f_idx_reg  <= s_tdata[38:33];
        end
    end

    assign product = f_lat_reg * f_lat_reg;

    always_comb
    begin
        push_item         = '0;
        push_item.mode    = f_mode_reg;
        push_item.latency = f_lat_reg;
        push_item.failed  = f_fail_reg;
        push_item.idx_ok  = (32'(f_idx_reg) < lsh_pkg::BIN_COUNT);
        push_item.idx     = push_item.idx_ok ? lsh_pkg::BIN_BITS'(f_idx_reg) : '0;
        push_item.sbin    = lsh_pkg::ceil_log2_bin(f_lat_reg);
        push_item.square  = lsh_pkg::SUM_BITS'(product);
    end

endmodule

[sv/lsh_queue.sv]
// Short queue of classified items between the front and back parts.
module lsh_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lsh_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           pop_valid,
    output lsh_pkg::item_t pop_item
);

    lsh_pkg::item_t                 slot_reg [lsh_pkg::QUEUE_DEPTH];
    logic [lsh_pkg::QPTR_BITS-1:0]  wr_ptr_reg;
    logic [lsh_pkg::QPTR_BITS-1:0]  rd_ptr_reg;
    logic [lsh_pkg::QCNT_BITS-1:0]  count_reg;

    assign full      = (32'(count_reg) == lsh_pkg::QUEUE_DEPTH);
    assign pop_valid = (count_reg != '0);
    assign pop_item  = slot_reg[rd_ptr_reg];

    function automatic logic [lsh_pkg::QPTR_BITS-1:0] ptr_inc(
        input logic [lsh_pkg::QPTR_BITS-1:0] p);
        return (32'(p) == lsh_pkg::QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[sv/lsh_back.sv]
// Back part: histogram memory, running totals and the result pipeline.
module lsh_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    input  lsh_pkg::item_t                    q_item,
    output logic                              q_pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lsh_pkg::OUT_DATA_BITS-1:0] m_tdata
);

    localparam int LB = lsh_pkg::LATENCY_BITS;
    localparam int CB = lsh_pkg::COUNT_BITS;
    localparam int SB = lsh_pkg::SUM_BITS;
    localparam int BB = lsh_pkg::BIN_BITS;

    // Update stage.
    logic           b_valid_reg;
    lsh_pkg::item_t b_item_reg;
    logic           b_take;
    logic           b_fire;

    // Totals stage and output register.
    logic             r_valid_reg;
    lsh_pkg::result_t r_res_reg;
    logic [CB-1:0]    r_snap_events_reg;
    logic [SB-1:0]    r_snap_sum_reg;
    logic [CB-1:0]    r_snap_fails_reg;
    logic             r_ready;
    logic             o_valid_reg;
    lsh_pkg::result_t o_res_reg;
    lsh_pkg::result_t o_res_next;
    logic             o_ready;

    // Running state.
    logic [CB-1:0] events_reg, events_next;
    logic [SB-1:0] sum_reg, sum_next;
    logic [SB-1:0] squares_reg, squares_next;
    logic [LB-1:0] min_reg, min_next;
    logic [LB-1:0] max_reg, max_next;
    logic [LB-1:0] pmin_reg, pmin_next;
    logic [LB-1:0] pmax_reg, pmax_next;
    logic [CB-1:0] fails_reg, fails_next;
    logic [CB-1:0] snap_events_reg;
    logic [SB-1:0] snap_sum_reg;
    logic [CB-1:0] snap_fails_reg;

    // Histogram memory with valid bits and a bypass of the latest write.
    logic [lsh_pkg::BIN_COUNT-1:0] hvalid_reg;
    logic                          lw_valid_reg;
    logic [BB-1:0]                 lw_addr_reg;
    logic [CB-1:0]                 lw_data_reg;
    logic [CB-1:0]                 rd_a;
    logic [CB-1:0]                 rd_b;
    logic [CB-1:0]                 hist_a;
    logic [CB-1:0]                 hist_b;
    logic [CB-1:0]                 hist_inc;
    logic [CB-1:0]                 bin_cnt;
    logic                          record;
    logic                          close;
    logic                          hist_wr;

    assign o_ready = !o_valid_reg || m_tready;
    assign r_ready = !r_valid_reg || o_ready;
    assign b_take  = !b_valid_reg || r_ready;
    assign q_pop   = q_valid && b_take;
    assign b_fire  = b_valid_reg && r_ready;

    assign record  = (b_item_reg.mode == lsh_pkg::MODE_RECORD);
    assign close   = (b_item_reg.mode == lsh_pkg::MODE_CLOSE);
    assign hist_wr = b_fire && record;

    lsh_ram #(
        .WIDTH (CB),
        .DEPTH (lsh_pkg::BIN_COUNT)
    ) u_hist (
        .clk       (clk),
        .wr_en     (hist_wr),
        .wr_addr   (b_item_reg.sbin),
        .wr_data   (hist_inc),
        .rd_en     (q_pop),
        .rd_addr_a (q_item.sbin),
        .rd_addr_b (q_item.idx),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    always_comb
    begin
        if (lw_valid_reg && lw_addr_reg == b_item_reg.sbin)
        begin
            hist_a = lw_data_reg;
        end
        else
        begin
            hist_a = hvalid_reg[b_item_reg.sbin] ? rd_a : '0;
        end
        if (lw_valid_reg && lw_addr_reg == b_item_reg.idx)
        begin
            hist_b = lw_data_reg;
        end
        else
        begin
            hist_b = hvalid_reg[b_item_reg.idx] ? rd_b : '0;
        end
        hist_inc = lsh_pkg::count_inc(hist_a);
        if (!b_item_reg.idx_ok)
        begin
            bin_cnt = '0;
        end
        else if (record && b_item_reg.idx == b_item_reg.sbin)
        begin
            bin_cnt = hist_inc;
        end
        else
        begin
            bin_cnt = hist_b;
        end
    end

    // Figures after the sample is taken in; unchanged for read and close.
    always_comb
    begin
        events_next  = events_reg;
        sum_next     = sum_reg;
        squares_next = squares_reg;
        min_next     = min_reg;
        max_next     = max_reg;
        pmin_next    = pmin_reg;
        pmax_next    = pmax_reg;
        fails_next   = fails_reg;
        if (record)
        begin
            events_next  = lsh_pkg::count_inc(events_reg);
            sum_next     = lsh_pkg::sat_add(sum_reg, SB'(b_item_reg.latency));
            squares_next = lsh_pkg::sat_add(squares_reg, b_item_reg.square);
            if (b_item_reg.latency < min_reg)
            begin
                min_next = b_item_reg.latency;
            end
            if (b_item_reg.latency > max_reg)
            begin
                max_next = b_item_reg.latency;
            end
            if (b_item_reg.latency < pmin_reg)
            begin
                pmin_next = b_item_reg.latency;
            end
            if (b_item_reg.latency > pmax_reg)
            begin
                pmax_next = b_item_reg.latency;
            end
            if (b_item_reg.failed)
            begin
                fails_next = lsh_pkg::count_inc(fails_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg     <= 1'b0;
            r_valid_reg     <= 1'b0;
            o_valid_reg     <= 1'b0;
            events_reg      <= '0;
            sum_reg         <= '0;
            squares_reg     <= '0;
            min_reg         <= '1;
            max_reg         <= '0;
            pmin_reg        <= '1;
            pmax_reg        <= '0;
            fails_reg       <= '0;
            snap_events_reg <= '0;
            snap_sum_reg    <= '0;
            snap_fails_reg  <= '0;
            hvalid_reg      <= '0;
            lw_valid_reg    <= 1'b0;
        end
        else
        begin
            if (b_take)
            begin
                b_valid_reg <= q_valid;
            end
            if (r_ready)
            begin
                r_valid_reg <= b_valid_reg;
            end
            if (o_ready)
            begin
                o_valid_reg <= r_valid_reg;
            end
            if (b_fire)
            begin
                events_reg  <= events_next;
                sum_reg     <= sum_next;
                squares_reg <= squares_next;
                min_reg     <= min_next;
                max_reg     <= max_next;
                fails_reg   <= fails_next;
                if (close)
                begin
                    snap_events_reg <= events_reg;
                    snap_sum_reg    <= sum_reg;
                    snap_fails_reg  <= fails_reg;
                    pmin_reg        <= '1;
                    pmax_reg        <= '0;
                end
                else
                begin
                    pmin_reg <= pmin_next;
                    pmax_reg <= pmax_next;
                end
            end
            if (hist_wr)
            begin
                hvalid_reg[b_item_reg.sbin] <= 1'b1;
                lw_valid_reg                <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            b_item_reg <= q_item;
        end
        if (hist_wr)
        begin
            lw_addr_reg <= b_item_reg.sbin;
            lw_data_reg <= hist_inc;
        end
        if (b_fire)
        begin
            r_res_reg.event_count  <= events_next;
            r_res_reg.latency_sum  <= sum_next;
            r_res_reg.latency_min  <= min_next;
            r_res_reg.latency_max  <= max_next;
            r_res_reg.fail_count   <= fails_next;
            r_res_reg.square_sum   <= squares_next;
            r_res_reg.period_min   <= pmin_next;
            r_res_reg.period_max   <= pmax_next;
            r_res_reg.bin_count    <= bin_cnt;
            r_res_reg.period_events      <= '0;
            r_res_reg.period_latency_sum <= '0;
            r_res_reg.period_fails       <= '0;
            r_snap_events_reg <= snap_events_reg;
            r_snap_sum_reg    <= snap_sum_reg;
            r_snap_fails_reg  <= snap_fails_reg;
        end
        if (o_ready && r_valid_reg)
        begin
            o_res_reg <= o_res_next;
        end
    end

    // Period figures are the totals less the snapshot of the last close.
    always_comb
    begin
        o_res_next                    = r_res_reg;
        o_res_next.period_events      = r_res_reg.event_count - r_snap_events_reg;
        o_res_next.period_latency_sum = r_res_reg.latency_sum - r_snap_sum_reg;
        o_res_next.period_fails       = r_res_reg.fail_count - r_snap_fails_reg;
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = o_res_reg;

endmodule

[sv/latency_stats_histogram_top.sv]
// Top level of the latency statistics histogram: front part, queue and back part.
//
//  channel  direction  tdata / tuser fields (low bit up)                  accepted when
//  s_*      in         tuser: mode; tdata: latency, failed, bin_index     s_tvalid && s_tready
//  m_*      out        tdata: the twelve result figures, see port below   m_tvalid && m_tready
//
// One item is accepted per cycle and one result leaves per cycle when the output side
// takes them; the update of the running totals and the read-modify-write of one
// histogram bin per item set that rate. An accepted item loads the input register and
// then passes through the queue, the update stage, the totals stage and the output
// register before its result is offered.
// Reset clears all figures and marks every histogram bin empty at once, with no sweep.
// A stall on the output side backs up through the pipeline; the two-entry queue lets the
// front keep taking items until it fills.
module latency_stats_histogram_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tdata: latency [31:0], failed [32], bin_index [38:33], zero [39]
    input  logic [lsh_pkg::IN_DATA_BITS-1:0]  s_tdata,
    // tuser: mode [1:0]
    input  logic [lsh_pkg::MODE_BITS-1:0]     s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // tdata: event_count [47:0], latency_sum [111:48], latency_min [143:112],
    // latency_max [175:144], fail_count [223:176], square_sum [287:224],
    // period_events [335:288], period_latency_sum [399:336], period_min [431:400],
    // period_max [463:432], period_fails [511:464], bin_count [559:512]
    output logic [lsh_pkg::OUT_DATA_BITS-1:0] m_tdata
);

    // Classified items flowing into and out of the queue.
    logic           push;
    lsh_pkg::item_t push_item;
    logic           q_full;
    logic           q_pop;
    logic           q_valid;
    lsh_pkg::item_t q_item;

    // The front part registers each item, finds its ceil-log2 bin and squares the
    // latency, so the back part only has to add and compare.
    lsh_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    // The queue decouples the input handshake from the output backpressure.
    lsh_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_item  (q_item)
    );

    // The back part owns all statistics state and the histogram memory.
    lsh_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

[tb/latency_stats_histogram_top_test.sv]
// Self-checking testbench for the latency statistics histogram top level.
module latency_stats_histogram_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import lsh_pkg::*;

    // Mode 3 has no meaning of its own; the block must treat it as a plain read.
    localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 1650;
    localparam int FIELD_COUNT  = 12;
    // Wait after the last expected result; this leaves ample room for a stray result.
    localparam int DRAIN_CYCLES = 20;

    // One item as the stimulus sees it, before it is packed onto the input bus.
    typedef struct {
        logic [MODE_BITS-1:0]    mode;
        logic [LATENCY_BITS-1:0] latency;
        logic                    failed;
        logic [IDX_BITS-1:0]     bin_index;
    } stat_item_t;

    logic                     clk      = 1'b0;
    logic                     rst_n    = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata  = '0;
    logic [MODE_BITS-1:0]     s_tuser  = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;

    // Items still waiting to be offered, and the figures that the block owes us.
    stat_item_t pending_items[$];
    result_t    expected_figures[$];
    int         error_count = 0;

    // Pacing state of the two sides.
    stat_item_t next_item;
    int         in_gap_left    = 0;
    int         in_burst       = 0;
    int         out_stall_left = 0;
    int         out_burst      = 0;
    int         stall_pick;

    // Shadow copy of everything the block keeps.
    logic [COUNT_BITS-1:0]   shadow_hist [BIN_COUNT];
    logic [COUNT_BITS-1:0]   shadow_events;
    logic [SUM_BITS-1:0]     shadow_sum;
    logic [SUM_BITS-1:0]     shadow_squares;
    logic [LATENCY_BITS-1:0] shadow_min;
    logic [LATENCY_BITS-1:0] shadow_max;
    logic [LATENCY_BITS-1:0] shadow_period_min;
    logic [LATENCY_BITS-1:0] shadow_period_max;
    logic [COUNT_BITS-1:0]   shadow_fails;
    logic [COUNT_BITS-1:0]   snap_events;
    logic [SUM_BITS-1:0]     snap_sum;
    logic [COUNT_BITS-1:0]   snap_fails;

    string field_label [0:FIELD_COUNT-1] = '{
        "event_count", "latency_sum", "latency_min", "latency_max",
        "fail_count", "square_sum", "period_events", "period_latency_sum",
        "period_min", "period_max", "period_fails", "bin_count"
    };

    latency_stats_histogram_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Counters stick at all ones instead of wrapping.
    function automatic logic [COUNT_BITS-1:0] bump_count(input logic [COUNT_BITS-1:0] c);
        if (c == {COUNT_BITS{1'b1}})
        begin
            return c;
        end
        return c + 1'b1;
    endfunction

    // The 64-bit sums clamp at all ones when the addition carries out.
    function automatic logic [SUM_BITS-1:0] add_clamped(input logic [SUM_BITS-1:0] a,
                                                        input logic [SUM_BITS-1:0] b);
        logic [SUM_BITS-1:0] s;
        s = a + b;
        if (s < a)
        begin
            return {SUM_BITS{1'b1}};
        end
        return s;
    endfunction

    // Applies one item to the shadow state and returns the figures it must produce.
    function automatic result_t predict_figures(input logic [MODE_BITS-1:0]    mode,
                                                input logic [LATENCY_BITS-1:0] lat,
                                                input logic                    failed,
                                                input logic [IDX_BITS-1:0]     bin_sel);
        result_t             r;
        logic [SUM_BITS-1:0] square;
        int                  bin_no;
        if (mode == MODE_RECORD)
        begin
            shadow_events  = bump_count(shadow_events);
            shadow_sum     = add_clamped(shadow_sum, SUM_BITS'(lat));
            // A 32-bit latency squared always fits in 64 bits.
            square         = SUM_BITS'(lat) * SUM_BITS'(lat);
            shadow_squares = add_clamped(shadow_squares, square);
            if (lat < shadow_min)
            begin
                shadow_min = lat;
            end
            if (lat > shadow_max)
            begin
                shadow_max = lat;
            end
            if (lat < shadow_period_min)
            begin
                shadow_period_min = lat;
            end
            if (lat > shadow_period_max)
            begin
                shadow_period_max = lat;
            end
            if (failed)
            begin
                shadow_fails = bump_count(shadow_fails);
            end
            // Smallest power of two that is not below the latency; 0 and 1 share bin 0.
            bin_no = 0;
            while (bin_no < 63 && (64'd1 << bin_no) < SUM_BITS'(lat))
            begin
                bin_no++;
            end
            if (bin_no >= BIN_COUNT)
            begin
                bin_no = BIN_COUNT - 1;
            end
            shadow_hist[bin_no] = bump_count(shadow_hist[bin_no]);
        end
        r.event_count        = shadow_events;
        r.latency_sum        = shadow_sum;
        r.latency_min        = shadow_min;
        r.latency_max        = shadow_max;
        r.fail_count         = shadow_fails;
        r.square_sum         = shadow_squares;
        r.period_events      = shadow_events - snap_events;
        r.period_latency_sum = shadow_sum - snap_sum;
        r.period_min         = shadow_period_min;
        r.period_max         = shadow_period_max;
        r.period_fails       = shadow_fails - snap_fails;
        r.bin_count          = (bin_sel < BIN_COUNT) ? shadow_hist[bin_sel] : '0;
        // A close reports the old period first, then starts a new one.
        if (mode == MODE_CLOSE)
        begin
            snap_events       = shadow_events;
            snap_sum          = shadow_sum;
            snap_fails        = shadow_fails;
            shadow_period_min = '1;
            shadow_period_max = '0;
        end
        return r;
    endfunction

    // Picks one field of a result by position, in the order of field_label.
    function automatic logic [63:0] field_of(input result_t r, input int k);
        case (k)
            0:       return 64'(r.event_count);
            1:       return r.latency_sum;
            2:       return 64'(r.latency_min);
            3:       return 64'(r.latency_max);
            4:       return 64'(r.fail_count);
            5:       return r.square_sum;
            6:       return 64'(r.period_events);
            7:       return r.period_latency_sum;
            8:       return 64'(r.period_min);
            9:       return 64'(r.period_max);
            10:      return 64'(r.period_fails);
            default: return 64'(r.bin_count);
        endcase
    endfunction

    // Gap length for either side: mostly none or short, sometimes long, and now and
    // then a stretch of back-to-back cycles with no gap at all.
    function automatic int pick_gap(inout int burst);
        int r;
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 99) < 2)
        begin
            burst = $urandom_range(30, 80);
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic queue_item(input logic [MODE_BITS-1:0]    mode,
                              input logic [LATENCY_BITS-1:0] lat,
                              input logic                    failed,
                              input logic [IDX_BITS-1:0]     bin_sel);
        stat_item_t it;
        it.mode      = mode;
        it.latency   = lat;
        it.failed    = failed;
        it.bin_index = bin_sel;
        pending_items.push_back(it);
    endtask

    // Input driver. A new item goes out only when the bus is free: either nothing
    // was offered, or the offered item was taken at this edge. The gap drawn after
    // each item keeps valid low between it and the next one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid    <= 1'b0;
            s_tdata     <= '0;
            s_tuser     <= '0;
            in_gap_left <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (in_gap_left != 0)
            begin
                s_tvalid    <= 1'b0;
                in_gap_left <= in_gap_left - 1;
            end
            else if (pending_items.size() != 0)
            begin
                next_item = pending_items.pop_front();
                // tdata carries latency, failed and bin_index from bit 0 up; the top
                // bit is byte padding.
                s_tdata     <= {1'b0, next_item.bin_index, next_item.failed,
                                next_item.latency};
                s_tuser     <= next_item.mode;
                s_tvalid    <= 1'b1;
                in_gap_left <= pick_gap(in_burst);
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Output back-pressure. Ready drops for a randomly drawn stall and then comes
    // back, independent of whether a result is waiting.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready       <= 1'b0;
            out_stall_left <= 0;
        end
        else if (out_stall_left != 0)
        begin
            m_tready       <= 1'b0;
            out_stall_left <= out_stall_left - 1;
        end
        else
        begin
            stall_pick = pick_gap(out_burst);
            m_tready       <= (stall_pick == 0);
            out_stall_left <= (stall_pick == 0) ? 0 : stall_pick - 1;
        end
    end

    // Prediction. Every item taken on the input side yields exactly one result, so
    // the expected figures are queued in input order.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BIN_COUNT; i++)
            begin
                shadow_hist[i] = '0;
            end
            shadow_events     = '0;
            shadow_sum        = '0;
            shadow_squares    = '0;
            shadow_min        = '1;
            shadow_max        = '0;
            shadow_period_min = '1;
            shadow_period_max = '0;
            shadow_fails      = '0;
            snap_events       = '0;
            snap_sum          = '0;
            snap_fails        = '0;
        end
        else if (s_tvalid && s_tready)
        begin
            expected_figures.push_back(predict_figures(s_tuser, s_tdata[31:0], s_tdata[32],
                                                       s_tdata[38:33]));
        end
    end

    // Result checker. Each result taken is held against the oldest expectation,
    // field by field.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_figures.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                begin
                    $display("%0t: result arrived with nothing expected: %h", $realtime,
                             m_tdata);
                end
            end
            else
            begin
                for (int k = 0; k < FIELD_COUNT; k++)
                begin
                    if (field_of(result_t'(m_tdata), k) !== field_of(expected_figures[0], k))
                    begin
                        error_count++;
                        if (error_count <= 10)
                        begin
                            $display("%0t: %s mismatch: expected %h, got %h", $realtime,
                                     field_label[k], field_of(expected_figures[0], k),
                                     field_of(result_t'(m_tdata), k));
                        end
                    end
                end
                void'(expected_figures.pop_front());
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int                      pick;
        logic [MODE_BITS-1:0]    mode;
        logic [LATENCY_BITS-1:0] lat;
        logic [IDX_BITS-1:0]     bin_sel;

        // Directed part. Reads straight after reset show the empty figures, including
        // the unused mode and a bin index past the histogram.
        queue_item(MODE_READ,   32'd0, 1'b0, 6'd0);
        queue_item(MODE_UNUSED, 32'd0, 1'b0, 6'd63);
        // Small latencies walk the low bins; 0 and 1 both land in bin 0.
        queue_item(MODE_RECORD, 32'd0, 1'b0, 6'd0);
        queue_item(MODE_RECORD, 32'd1, 1'b1, 6'd0);
        queue_item(MODE_RECORD, 32'd2, 1'b0, 6'd1);
        queue_item(MODE_RECORD, 32'd3, 1'b0, 6'd2);
        queue_item(MODE_RECORD, 32'd4, 1'b1, 6'd2);
        queue_item(MODE_RECORD, 32'd5, 1'b0, 6'd3);
        queue_item(MODE_RECORD, 32'h4000_0000, 1'b0, 6'd30);
        queue_item(MODE_RECORD, 32'h8000_0000, 1'b0, 6'd31);
        // Anything above 2^31 goes to the last bin.
        queue_item(MODE_RECORD, 32'h8000_0001, 1'b1, 6'd32);
        queue_item(MODE_READ,   32'd0, 1'b0, 6'd33);
        queue_item(MODE_CLOSE,  32'd0, 1'b0, 6'd32);
        queue_item(MODE_READ,   32'd0, 1'b0, 6'd0);
        // A close of an empty period, one sample, then the unused mode carrying a sample
        // that must not be counted.
        queue_item(MODE_CLOSE,  32'd0, 1'b0, 6'd1);
        queue_item(MODE_RECORD, 32'd7, 1'b0, 6'd3);
        queue_item(MODE_UNUSED, 32'hFFFF_FFFF, 1'b1, 6'd3);
        // Three full-scale samples push the sum of squares into saturation.
        queue_item(MODE_RECORD, 32'hFFFF_FFFF, 1'b0, 6'd32);
        queue_item(MODE_RECORD, 32'hFFFF_FFFF, 1'b1, 6'd32);
        queue_item(MODE_RECORD, 32'hFFFF_FFFF, 1'b0, 6'd32);
        queue_item(MODE_CLOSE,  32'd0, 1'b0, 6'd63);
        queue_item(MODE_READ,   32'd0, 1'b0, 6'd32);

        // Random part: mostly samples spread over all magnitudes, with reads, closes
        // and the unused mode mixed in.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                mode = MODE_RECORD;
            end
            else if (pick < 82)
            begin
                mode = MODE_READ;
            end
            else if (pick < 92)
            begin
                mode = MODE_CLOSE;
            end
            else
            begin
                mode = MODE_UNUSED;
            end
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                lat = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 1)) : 32'hFFFF_FFFF;
            end
            else
            begin
                lat = $urandom >> $urandom_range(0, 31);
            end
            if ($urandom_range(0, 9) == 0)
            begin
                bin_sel = IDX_BITS'($urandom_range(BIN_COUNT, 63));
            end
            else
            begin
                bin_sel = IDX_BITS'($urandom_range(0, BIN_COUNT - 1));
            end
            queue_item(mode, lat, 1'($urandom_range(0, 1)), bin_sel);
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until the driver has handed over every item, then until every result
        // is in, then a little longer to catch any stray extra result.
        while (pending_items.size() != 0 || s_tvalid)
        begin
            @(posedge clk);
        end
        while (expected_figures.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_figures.size() == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog for a block that stops moving items.
    initial
    begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
